@@ src/aff_pkg.sv @@
package aff_pkg;

  // block configuration
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int COUNT_BITS = 16;

  // port widths
  localparam int IN_W   = 16;
  localparam int COEF_W = 32;
  localparam int STAT_W = 2;

  // derived widths
  localparam int SUM_W  = 2 * COORD_BITS + COUNT_BITS;
  localparam int PROD_W = 2 * COORD_BITS;
  localparam int ADJ_W  = 2 * SUM_W + 2;
  localparam int ACC_W  = 3 * SUM_W + 8;
  localparam int CNT_W  = COUNT_BITS + 1;

  // wide multiplier built from limb products
  localparam int LIMB_W  = 32;
  localparam int A_LIMBS = (ADJ_W + LIMB_W - 1) / LIMB_W;
  localparam int B_LIMBS = (SUM_W + LIMB_W - 1) / LIMB_W;
  localparam int AMAG_W  = A_LIMBS * LIMB_W;
  localparam int BMAG_W  = B_LIMBS * LIMB_W;
  localparam int AI_W    = (A_LIMBS > 1) ? $clog2(A_LIMBS) : 1;
  localparam int BI_W    = (B_LIMBS > 1) ? $clog2(B_LIMBS) : 1;
  localparam int SH_W    = $clog2(A_LIMBS + B_LIMBS);

  // divider
  localparam int DIV_W  = ACC_W + FRAC_BITS + COEF_W + 2;
  localparam int DCNT_W = $clog2(COEF_W + 2);

  // moment storage
  localparam int NSUM     = 9;
  localparam int SC_DEPTH = 2 * NSUM;
  localparam int SC_AW    = $clog2(SC_DEPTH);
  localparam int IDX_W    = $clog2(NSUM);

  typedef enum logic [STAT_W-1:0] {
    FIT_OK   = 2'd0,
    FIT_FEW  = 2'd1,
    FIT_SING = 2'd2
  } fit_status_t;

  typedef enum logic [1:0] {
    WB_NONE,
    WB_ADJ,
    WB_DET,
    WB_COEF
  } wb_t;

  typedef struct packed {
    logic             a_adj;
    logic [IDX_W-1:0] a_idx;
    logic             b_cross;
    logic [IDX_W-1:0] b_idx;
    logic             neg;
    logic             clr;
    wb_t              wb;
    logic [IDX_W-1:0] wb_idx;
  } uop_t;

  typedef struct packed {
    logic        load_item;
    logic        acc_en;
    logic        acc_cross;
    logic [1:0]  acc_r;
    logic [1:0]  acc_c;
    logic        mac_start;
    uop_t        uop;
    logic        clear_sums;
    logic        set_status;
    fit_status_t status;
    logic        clr_coef;
  } cmd_t;

  typedef struct packed {
    logic mac_done;
    logic det_zero;
    logic few_pairs;
  } stat_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_ACC,
    CS_DRAIN,
    CS_CHECK,
    CS_ISSUE,
    CS_WAIT,
    CS_DETCHK,
    CS_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PH_ADJ,
    PH_DET,
    PH_NUM
  } phase_t;

  typedef enum logic [2:0] {
    MP_IDLE,
    MP_LOAD,
    MP_MUL,
    MP_DRAIN,
    MP_WB,
    MP_DIV
  } mac_phase_t;

  // adjugate entry i = s[P]*s[Q] - s[M]*s[N]
  localparam logic [IDX_W-1:0] ADJ_P [NSUM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam logic [IDX_W-1:0] ADJ_Q [NSUM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam logic [IDX_W-1:0] ADJ_M [NSUM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam logic [IDX_W-1:0] ADJ_N [NSUM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

  // row-major index of a 3x3 entry
  function automatic logic [IDX_W-1:0] idx3(input logic [1:0] r, input logic [1:0] c);
    logic [IDX_W-1:0] rr;
    rr = IDX_W'(r);
    return (rr << 1) + rr + IDX_W'(c);
  endfunction

endpackage

@@ src/aff_div.sv @@
module aff_div
  import aff_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ACC_W-1:0]  num,
  input  logic [ACC_W-1:0]  den,
  output logic              done,
  output logic [COEF_W-1:0] coef
);

  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  dsh_r, dsh_nxt;
  logic [COEF_W:0]   q_r, q_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              neg_r, neg_nxt;
  logic [ACC_W-1:0]  num_mag, den_mag;
  logic              ge;
  logic              big;
  logic [COEF_W-1:0] mag;

  assign num_mag = num[ACC_W-1] ? (~num + 1'b1) : num;
  assign den_mag = den[ACC_W-1] ? (~den + 1'b1) : den;
  assign ge      = (rem_r >= dsh_r);

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    if (start) begin
      // rounded quotient (|n|*2^(f+1) + |d|) / 2|d|, 33 quotient bits
      rem_nxt  = (DIV_W'(num_mag) << (FRAC_BITS + 1)) + DIV_W'(den_mag);
      dsh_nxt  = DIV_W'(den_mag) << (COEF_W + 1);
      q_nxt    = '0;
      cnt_nxt  = DCNT_W'(COEF_W + 1);
      busy_nxt = 1'b1;
      neg_nxt  = num[ACC_W-1] ^ den[ACC_W-1];
    end else if (busy_r) begin
      if (ge) rem_nxt = rem_r - dsh_r;
      dsh_nxt = dsh_r >> 1;
      q_nxt   = {q_r[COEF_W-1:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // saturate to the signed coefficient range
  assign big = q_r[COEF_W];
  assign mag = q_r[COEF_W-1:0];

  always_comb begin
    if (neg_r) begin
      if (big || mag[COEF_W-1]) coef = {1'b1, {(COEF_W-1){1'b0}}};
      else                      coef = ~mag + 1'b1;
    end else begin
      if (big || mag[COEF_W-1]) coef = {1'b0, {(COEF_W-1){1'b1}}};
      else                      coef = mag;
    end
  end

  assign done = done_r;

endmodule

@@ src/aff_dp.sv @@
module aff_dp
  import aff_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [IN_W-1:0]   src_x,
  input  logic signed [IN_W-1:0]   src_y,
  input  logic signed [IN_W-1:0]   src_w,
  input  logic signed [IN_W-1:0]   dst_x,
  input  logic signed [IN_W-1:0]   dst_y,
  input  logic signed [IN_W-1:0]   dst_w,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  output logic signed [COEF_W-1:0] coef [NSUM],
  output logic [STAT_W-1:0]        status
);

  // current pair
  logic signed [COORD_BITS-1:0] x_r [3];
  logic signed [COORD_BITS-1:0] u_r [3];
  logic [CNT_W-1:0]             cnt_r;

  // moment sums: entries 0..8 source, 9..17 cross
  logic signed [SUM_W-1:0] sc_mem [SC_DEPTH];
  logic [SC_DEPTH-1:0]     sc_vld_r;
  logic signed [SUM_W-1:0] rd0_r, rd1_r;
  logic [SC_AW-1:0]        rd0_addr, rd1_addr;

  // accumulate pipeline
  logic signed [PROD_W-1:0] prod_r;
  logic [SC_AW-1:0]         waddr_r;
  logic                     wen_r;
  logic signed [COORD_BITS-1:0] mul_a;

  // adjugate and determinant
  logic [ADJ_W-1:0] adj_mem [NSUM];
  logic [ADJ_W-1:0] adj_rd_r;
  logic [ACC_W-1:0] det_r;

  // wide multiply-accumulate
  mac_phase_t          mp_r, mp_nxt;
  uop_t                uop_r;
  logic [AMAG_W-1:0]   amag_r;
  logic [BMAG_W-1:0]   bmag_r;
  logic                neg_r;
  logic [AI_W-1:0]     ai_r;
  logic [BI_W-1:0]     bi_r;
  logic [2*LIMB_W-1:0] pp_r;
  logic [SH_W-1:0]     sh_r;
  logic                ppv_r;
  logic [ACC_W-1:0]    acc_r;
  logic [ACC_W-1:0]    term;
  logic signed [ADJ_W-1:0] a_val;
  logic [ADJ_W-1:0]    a_abs;
  logic [SUM_W-1:0]    b_abs;
  logic                limb_last;

  logic signed [COEF_W-1:0] coef_r [NSUM];
  logic [STAT_W-1:0]        status_r;

  logic              div_start, div_done;
  logic [COEF_W-1:0] div_coef;

  // item capture and pair count
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      x_r[0] <= src_x[COORD_BITS-1:0];
      x_r[1] <= src_y[COORD_BITS-1:0];
      x_r[2] <= src_w[COORD_BITS-1:0];
      u_r[0] <= dst_x[COORD_BITS-1:0];
      u_r[1] <= dst_y[COORD_BITS-1:0];
      u_r[2] <= dst_w[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.clear_sums) begin
      cnt_r <= '0;
    end else if (cmd.load_item && (cnt_r != {CNT_W{1'b1}})) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // moment store ports
  assign rd0_addr = cmd.acc_en
                  ? (cmd.acc_cross ? SC_AW'(idx3(cmd.acc_r, cmd.acc_c)) + SC_AW'(NSUM)
                                   : SC_AW'(idx3(cmd.acc_r, cmd.acc_c)))
                  : (cmd.uop.b_cross ? SC_AW'(cmd.uop.b_idx) + SC_AW'(NSUM)
                                     : SC_AW'(cmd.uop.b_idx));
  assign rd1_addr = SC_AW'(cmd.uop.a_idx);

  always_ff @(posedge clk) begin
    rd0_r <= sc_vld_r[rd0_addr] ? sc_mem[rd0_addr] : '0;
    rd1_r <= sc_vld_r[rd1_addr] ? sc_mem[rd1_addr] : '0;
    if (wen_r) sc_mem[waddr_r] <= rd0_r + SUM_W'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_vld_r <= '0;
    end else if (cmd.clear_sums) begin
      sc_vld_r <= '0;
    end else if (wen_r) begin
      sc_vld_r[waddr_r] <= 1'b1;
    end
  end

  assign mul_a = cmd.acc_cross ? u_r[cmd.acc_r] : x_r[cmd.acc_r];

  always_ff @(posedge clk) begin
    prod_r  <= mul_a * x_r[cmd.acc_c];
    waddr_r <= rd0_addr;
    if (!rst_n) wen_r <= 1'b0;
    else        wen_r <= cmd.acc_en;
  end

  // adjugate store
  always_ff @(posedge clk) begin
    adj_rd_r <= adj_mem[cmd.uop.a_idx];
    if (mp_r == MP_WB && uop_r.wb == WB_ADJ) adj_mem[uop_r.wb_idx] <= acc_r[ADJ_W-1:0];
  end

  // multiply-accumulate sequence
  assign limb_last = (ai_r == AI_W'(A_LIMBS - 1)) && (bi_r == BI_W'(B_LIMBS - 1));

  always_comb begin
    mp_nxt = mp_r;
    case (mp_r)
      MP_IDLE:  if (cmd.mac_start) mp_nxt = MP_LOAD;
      MP_LOAD:  mp_nxt = MP_MUL;
      MP_MUL:   if (limb_last) mp_nxt = MP_DRAIN;
      MP_DRAIN: mp_nxt = MP_WB;
      MP_WB:    mp_nxt = (uop_r.wb == WB_COEF) ? MP_DIV : MP_IDLE;
      MP_DIV:   if (div_done) mp_nxt = MP_IDLE;
      default:  mp_nxt = MP_IDLE;
    endcase
  end

  assign a_val = uop_r.a_adj ? signed'(adj_rd_r) : ADJ_W'(rd1_r);
  assign a_abs = a_val[ADJ_W-1] ? (~a_val + 1'b1) : a_val;
  assign b_abs = rd0_r[SUM_W-1] ? (~rd0_r + 1'b1) : rd0_r;
  assign term  = ACC_W'(pp_r) << (sh_r * LIMB_W);

  always_ff @(posedge clk) begin
    if (!rst_n) mp_r <= MP_IDLE;
    else        mp_r <= mp_nxt;
  end

  always_ff @(posedge clk) begin
    if (mp_r == MP_IDLE && cmd.mac_start) uop_r <= cmd.uop;
    if (mp_r == MP_LOAD) begin
      amag_r <= AMAG_W'(a_abs);
      bmag_r <= BMAG_W'(b_abs);
      neg_r  <= a_val[ADJ_W-1] ^ rd0_r[SUM_W-1] ^ uop_r.neg;
      ai_r   <= '0;
      bi_r   <= '0;
    end else if (mp_r == MP_MUL) begin
      if (bi_r == BI_W'(B_LIMBS - 1)) begin
        bi_r <= '0;
        ai_r <= ai_r + 1'b1;
      end else begin
        bi_r <= bi_r + 1'b1;
      end
    end
    pp_r  <= amag_r[ai_r*LIMB_W +: LIMB_W] * bmag_r[bi_r*LIMB_W +: LIMB_W];
    sh_r  <= SH_W'(ai_r) + SH_W'(bi_r);
    if (mp_r == MP_LOAD && uop_r.clr) acc_r <= '0;
    else if (ppv_r)                   acc_r <= neg_r ? acc_r - term : acc_r + term;
    if (mp_r == MP_WB && uop_r.wb == WB_DET) det_r <= acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ppv_r <= 1'b0;
    else        ppv_r <= (mp_r == MP_MUL);
  end

  assign div_start = (mp_r == MP_WB) && (uop_r.wb == WB_COEF);

  aff_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_r),
    .den   (det_r),
    .done  (div_done),
    .coef  (div_coef)
  );

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.clr_coef) begin
      for (int i = 0; i < NSUM; i++) coef_r[i] <= '0;
    end else if (mp_r == MP_DIV && div_done) begin
      coef_r[uop_r.wb_idx] <= div_coef;
    end
    if (cmd.set_status) status_r <= cmd.status;
  end

  assign stat.mac_done  = ((mp_r == MP_WB) && (uop_r.wb != WB_COEF))
                       || ((mp_r == MP_DIV) && div_done);
  assign stat.det_zero  = (det_r == '0);
  assign stat.few_pairs = (cnt_r < CNT_W'(3));

  assign coef   = coef_r;
  assign status = status_r;

endmodule

@@ src/aff_ctrl.sv @@
module aff_ctrl
  import aff_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_last,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  ctrl_state_t      state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic             t_r, t_nxt;
  logic [1:0]       k_r, k_nxt;
  logic [1:0]       r_r, r_nxt;
  logic [1:0]       j_r, j_nxt;
  logic             ax_r, ax_nxt;
  logic [1:0]       ar_r, ar_nxt;
  logic [1:0]       ac_r, ac_nxt;
  logic             last_r, last_nxt;
  logic             ov_r, ov_nxt;
  logic             in_xfer;

  assign in_xfer = in_valid && (state_r == CS_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    i_nxt     = i_r;
    t_nxt     = t_r;
    k_nxt     = k_r;
    r_nxt     = r_r;
    j_nxt     = j_r;
    ax_nxt    = ax_r;
    ar_nxt    = ar_r;
    ac_nxt    = ac_r;
    last_nxt  = last_r;
    case (state_r)
      CS_IDLE: begin
        if (in_xfer) begin
          state_nxt = CS_ACC;
          last_nxt  = in_last;
          ax_nxt    = 1'b0;
          ar_nxt    = '0;
          ac_nxt    = '0;
        end
      end
      CS_ACC: begin
        if (ac_r == 2'd2) begin
          ac_nxt = '0;
          if (ar_r == 2'd2) begin
            ar_nxt = '0;
            ax_nxt = 1'b1;
            if (ax_r) state_nxt = CS_DRAIN;
          end else begin
            ar_nxt = ar_r + 1'b1;
          end
        end else begin
          ac_nxt = ac_r + 1'b1;
        end
      end
      CS_DRAIN: state_nxt = last_r ? CS_CHECK : CS_IDLE;
      CS_CHECK: begin
        if (!ov_r) begin
          if (stat.few_pairs) begin
            state_nxt = CS_IDLE;
          end else begin
            state_nxt = CS_ISSUE;
            phase_nxt = PH_ADJ;
            i_nxt     = '0;
            t_nxt     = 1'b0;
          end
        end
      end
      CS_ISSUE: state_nxt = CS_WAIT;
      CS_WAIT: begin
        if (stat.mac_done) begin
          state_nxt = CS_ISSUE;
          case (phase_r)
            PH_ADJ: begin
              t_nxt = ~t_r;
              if (t_r) begin
                if (i_r == IDX_W'(NSUM - 1)) begin
                  phase_nxt = PH_DET;
                  k_nxt     = '0;
                end else begin
                  i_nxt = i_r + 1'b1;
                end
              end
            end
            PH_DET: begin
              if (k_r == 2'd2) state_nxt = CS_DETCHK;
              else             k_nxt = k_r + 1'b1;
            end
            PH_NUM: begin
              if (k_r != 2'd2) begin
                k_nxt = k_r + 1'b1;
              end else begin
                k_nxt = '0;
                if (j_r != 2'd2) begin
                  j_nxt = j_r + 1'b1;
                end else begin
                  j_nxt = '0;
                  if (r_r != 2'd2) r_nxt = r_r + 1'b1;
                  else             state_nxt = CS_DONE;
                end
              end
            end
            default: state_nxt = CS_IDLE;
          endcase
        end
      end
      CS_DETCHK: begin
        if (stat.det_zero) begin
          state_nxt = CS_IDLE;
        end else begin
          state_nxt = CS_ISSUE;
          phase_nxt = PH_NUM;
          r_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
        end
      end
      CS_DONE: state_nxt = CS_IDLE;
      default: state_nxt = CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    cmd.uop.wb = WB_NONE;
    cmd.status = FIT_OK;
    in_stall  = (state_r != CS_IDLE);
    cmd.load_item = in_xfer;
    cmd.acc_en    = (state_r == CS_ACC);
    cmd.acc_cross = ax_r;
    cmd.acc_r     = ar_r;
    cmd.acc_c     = ac_r;
    cmd.mac_start = (state_r == CS_ISSUE);
    case (phase_r)
      PH_ADJ: begin
        cmd.uop.a_adj = 1'b0;
        cmd.uop.a_idx = t_r ? ADJ_M[i_r] : ADJ_P[i_r];
        cmd.uop.b_idx = t_r ? ADJ_N[i_r] : ADJ_Q[i_r];
        cmd.uop.neg   = t_r;
        cmd.uop.clr   = ~t_r;
        cmd.uop.wb    = t_r ? WB_ADJ : WB_NONE;
        cmd.uop.wb_idx = i_r;
      end
      PH_DET: begin
        cmd.uop.a_adj = 1'b1;
        cmd.uop.a_idx = idx3(k_r, 2'd0);
        cmd.uop.b_idx = IDX_W'(k_r);
        cmd.uop.clr   = (k_r == 2'd0);
        cmd.uop.wb    = (k_r == 2'd2) ? WB_DET : WB_NONE;
      end
      PH_NUM: begin
        cmd.uop.a_adj   = 1'b1;
        cmd.uop.a_idx   = idx3(k_r, j_r);
        cmd.uop.b_cross = 1'b1;
        cmd.uop.b_idx   = idx3(r_r, k_r);
        cmd.uop.clr     = (k_r == 2'd0);
        cmd.uop.wb      = (k_r == 2'd2) ? WB_COEF : WB_NONE;
        cmd.uop.wb_idx  = idx3(r_r, j_r);
      end
      default: cmd.uop.wb = WB_NONE;
    endcase
    case (state_r)
      CS_CHECK: begin
        if (!ov_r && stat.few_pairs) begin
          cmd.set_status = 1'b1;
          cmd.status     = FIT_FEW;
          cmd.clr_coef   = 1'b1;
          cmd.clear_sums = 1'b1;
        end
      end
      CS_DETCHK: begin
        if (stat.det_zero) begin
          cmd.set_status = 1'b1;
          cmd.status     = FIT_SING;
          cmd.clr_coef   = 1'b1;
          cmd.clear_sums = 1'b1;
        end
      end
      CS_DONE: begin
        cmd.set_status = 1'b1;
        cmd.status     = FIT_OK;
        cmd.clear_sums = 1'b1;
      end
      default: cmd.set_status = 1'b0;
    endcase
  end

  assign ov_nxt    = cmd.set_status || (ov_r && out_stall);
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    t_r    <= t_nxt;
    k_r    <= k_nxt;
    r_r    <= r_nxt;
    j_r    <= j_nxt;
    ax_r   <= ax_nxt;
    ar_r   <= ar_nxt;
    ac_r   <= ac_nxt;
    if (!rst_n) begin
      state_r <= CS_IDLE;
      phase_r <= PH_ADJ;
      last_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      last_r  <= last_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

@@ src/affine_fit_least_squares.sv @@
// Least-squares 3x3 transform fit from matched point pairs. Each input transfer carries a
// homogeneous source triple and destination triple; the block adds the pair into the source
// moment sums (X*X^t) and cross moment sums (U*X^t), one 16x16 product per cycle, so a pair
// occupies the input through its acceptance, 18 products and one write-back. On the transfer
// marked last it solves T = sum(U X^t) * inv(sum(X X^t)) exactly as C*adj(S)/det(S): 48
// wide multiply-accumulates on a shared 32x32 limb multiplier and nine restoring divisions
// of 33 steps, then presents one result of nine signed Q15.16 coefficients, rounded half
// away from zero and saturated, with a status:
// 0 solved, 1 fewer than three pairs, 2 singular moment matrix (coefficients zero on both).
// All sums clear after each result. Pairs of the next set are taken while a result waits;
// the next solve holds until that result has been transferred.
module affine_fit_least_squares
  import aff_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [IN_W-1:0]   in_src_x,
  input  logic signed [IN_W-1:0]   in_src_y,
  input  logic signed [IN_W-1:0]   in_src_w,
  input  logic signed [IN_W-1:0]   in_dst_x,
  input  logic signed [IN_W-1:0]   in_dst_y,
  input  logic signed [IN_W-1:0]   in_dst_w,
  input  logic                     in_last,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [COEF_W-1:0] out_coef_00,
  output logic signed [COEF_W-1:0] out_coef_01,
  output logic signed [COEF_W-1:0] out_coef_02,
  output logic signed [COEF_W-1:0] out_coef_10,
  output logic signed [COEF_W-1:0] out_coef_11,
  output logic signed [COEF_W-1:0] out_coef_12,
  output logic signed [COEF_W-1:0] out_coef_20,
  output logic signed [COEF_W-1:0] out_coef_21,
  output logic signed [COEF_W-1:0] out_coef_22,
  output logic [STAT_W-1:0]        out_status
);

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  // coefficient registers, row-major
  logic signed [COEF_W-1:0] coef [NSUM];

  // sequencer: pair accumulation, solve schedule, result handshake
  aff_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: moment sums, wide multiplier, divider, result registers
  aff_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .src_x  (in_src_x),
    .src_y  (in_src_y),
    .src_w  (in_src_w),
    .dst_x  (in_dst_x),
    .dst_y  (in_dst_y),
    .dst_w  (in_dst_w),
    .cmd    (cmd),
    .stat   (stat),
    .coef   (coef),
    .status (out_status)
  );

  // result fields held until transfer
  assign out_coef_00 = coef[0];
  assign out_coef_01 = coef[1];
  assign out_coef_02 = coef[2];
  assign out_coef_10 = coef[3];
  assign out_coef_11 = coef[4];
  assign out_coef_12 = coef[5];
  assign out_coef_20 = coef[6];
  assign out_coef_21 = coef[7];
  assign out_coef_22 = coef[8];

endmodule
